### sv/okl_pkg.sv
package okl_pkg;

  localparam int MODE_W = 3;
  localparam int KEY_W  = 32;
  localparam int POS_W  = 6;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 7;

  localparam logic [MODE_W-1:0] MODE_INS_HEAD = 3'd0;
  localparam logic [MODE_W-1:0] MODE_INS_TAIL = 3'd1;
  localparam logic [MODE_W-1:0] MODE_REM_KEY  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_REM_POS  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_EXISTS   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_DUMP     = 3'd5;

  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd2;

  typedef logic signed [KEY_W-1:0] key_t;

endpackage

### sv/okl_key_ram.sv
module okl_key_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  okl_pkg::key_t   wdata,
  input  logic            re,
  input  logic [AW-1:0]   raddr,
  output okl_pkg::key_t   rdata
);

  okl_pkg::key_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/ordered_key_list_engine_top.sv
// Ordered list of up to CAPACITY signed 32-bit keys held in a single synchronous key
// memory (one write and one registered read per cycle). One request is handled at a
// time. Insert at tail, and any request that is rejected or finds an empty list, goes
// straight from idle to its result. Insert at head moves every stored entry up one
// place, then writes the new key at the head. Remove by key and exists scan from the
// head. A removal, by key after the scan or by position, moves the entries behind the
// hole down one place. Dump gives one result per entry. Each entry moved or dumped is
// first read from the key memory, then written or sent out. A result stalled at the
// output register holds back the next dump read and the emit of the next result. A new
// request is accepted while the last result still waits there. No clearing pass is
// needed after reset.
module ordered_key_list_engine_top #(
  parameter int CAPACITY = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [okl_pkg::MODE_W-1:0]        mode,
  input  okl_pkg::key_t                     key,
  input  logic [okl_pkg::POS_W-1:0]         position,
  output logic                              out_valid,
  input  logic                              out_stall,
  output okl_pkg::key_t                     entry_key,
  output logic                              found,
  output logic [okl_pkg::STAT_W-1:0]        status,
  output logic [okl_pkg::CNT_W-1:0]         entry_count,
  output logic                              last
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SH_RD  = 4'd1;
  localparam logic [3:0] S_SH_WR  = 4'd2;
  localparam logic [3:0] S_HD_WR  = 4'd3;
  localparam logic [3:0] S_SR_RD  = 4'd4;
  localparam logic [3:0] S_SR_CMP = 4'd5;
  localparam logic [3:0] S_DN_RD  = 4'd6;
  localparam logic [3:0] S_DN_WR  = 4'd7;
  localparam logic [3:0] S_DP_RD  = 4'd8;
  localparam logic [3:0] S_DP_OUT = 4'd9;
  localparam logic [3:0] S_EMIT   = 4'd10;

  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

  logic [3:0]                 state;
  logic [CW-1:0]              count;
  logic [CW-1:0]              idx;
  logic [CW-1:0]              idx_inc;
  logic [CW-1:0]              idx_dec;
  okl_pkg::key_t              op_key;
  logic                       op_exists;
  logic                       res_found;
  logic [okl_pkg::STAT_W-1:0] res_status;

  logic                       in_fire;
  logic                       out_free;
  logic                       pos_ok;

  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  okl_pkg::key_t              mem_wdata;
  logic                       mem_re;
  logic [AW-1:0]              mem_raddr;
  okl_pkg::key_t              mem_rdata;

  assign in_stall = (state != S_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign idx_inc  = idx + CW'(1);
  assign idx_dec  = idx - CW'(1);
  assign pos_ok   = ({1'b0, position} < okl_pkg::CNT_W'(count));

  okl_key_ram #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = count[AW-1:0];
    mem_wdata = key;
    mem_re    = 1'b0;
    mem_raddr = idx[AW-1:0];
    case (state)
      S_IDLE: begin
        if (in_fire && count != CAP_CNT &&
            (mode == okl_pkg::MODE_INS_TAIL ||
             (mode == okl_pkg::MODE_INS_HEAD && count == '0))) begin
          mem_we = 1'b1;
        end
      end
      S_SH_RD: begin
        mem_re    = 1'b1;
        mem_raddr = idx_dec[AW-1:0];
      end
      S_SH_WR: begin
        mem_we    = 1'b1;
        mem_waddr = idx[AW-1:0];
        mem_wdata = mem_rdata;
      end
      S_HD_WR: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = op_key;
      end
      S_SR_RD: begin
        mem_re = 1'b1;
      end
      S_DN_RD: begin
        if (idx_inc < count) begin
          mem_re    = 1'b1;
          mem_raddr = idx_inc[AW-1:0];
        end
      end
      S_DN_WR: begin
        mem_we    = 1'b1;
        mem_waddr = idx[AW-1:0];
        mem_wdata = mem_rdata;
      end
      S_DP_RD: begin
        mem_re = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          op_key     <= key;
          op_exists  <= (mode == okl_pkg::MODE_EXISTS);
          res_found  <= 1'b0;
          res_status <= okl_pkg::STAT_OK;
          idx        <= '0;
          state      <= S_EMIT;
          case (mode)
            okl_pkg::MODE_INS_HEAD, okl_pkg::MODE_INS_TAIL: begin
              if (count == CAP_CNT) begin
                res_status <= okl_pkg::STAT_FULL;
              end else if (mode == okl_pkg::MODE_INS_TAIL || count == '0) begin
                count <= count + CW'(1);
              end else begin
                idx   <= count;
                state <= S_SH_RD;
              end
            end
            okl_pkg::MODE_REM_KEY, okl_pkg::MODE_EXISTS: begin
              if (count == '0) begin
                if (mode == okl_pkg::MODE_REM_KEY) begin
                  res_status <= okl_pkg::STAT_NOTFOUND;
                end
              end else begin
                state <= S_SR_RD;
              end
            end
            okl_pkg::MODE_REM_POS: begin
              if (pos_ok) begin
                idx   <= CW'(position);
                state <= S_DN_RD;
              end else begin
                res_status <= okl_pkg::STAT_NOTFOUND;
              end
            end
            okl_pkg::MODE_DUMP: begin
              if (count != '0) begin
                state <= S_DP_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SH_RD: begin
        state <= S_SH_WR;
      end
      S_SH_WR: begin
        idx <= idx_dec;
        if (idx == CW'(1)) begin
          state <= S_HD_WR;
        end else begin
          state <= S_SH_RD;
        end
      end
      S_HD_WR: begin
        count <= count + CW'(1);
        state <= S_EMIT;
      end
      S_SR_RD: begin
        state <= S_SR_CMP;
      end
      S_SR_CMP: begin
        if (mem_rdata == op_key) begin
          if (op_exists) begin
            res_found <= 1'b1;
            state     <= S_EMIT;
          end else begin
            state <= S_DN_RD;
          end
        end else if (idx_inc == count) begin
          if (!op_exists) begin
            res_status <= okl_pkg::STAT_NOTFOUND;
          end
          state <= S_EMIT;
        end else begin
          idx   <= idx_inc;
          state <= S_SR_RD;
        end
      end
      S_DN_RD: begin
        if (idx_inc < count) begin
          state <= S_DN_WR;
        end else begin
          count     <= count - CW'(1);
          res_found <= 1'b1;
          state     <= S_EMIT;
        end
      end
      S_DN_WR: begin
        idx   <= idx_inc;
        state <= S_DN_RD;
      end
      S_DP_RD: begin
        state <= S_DP_OUT;
      end
      S_DP_OUT: begin
        if (out_free) begin
          out_valid   <= 1'b1;
          entry_key   <= mem_rdata;
          found       <= 1'b1;
          status      <= okl_pkg::STAT_OK;
          entry_count <= okl_pkg::CNT_W'(count);
          last        <= (idx_inc == count);
          idx         <= idx_inc;
          state       <= (idx_inc == count) ? S_IDLE : S_DP_RD;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid   <= 1'b1;
          entry_key   <= '0;
          found       <= res_found;
          status      <= res_status;
          entry_count <= okl_pkg::CNT_W'(count);
          last        <= 1'b1;
          state       <= S_IDLE;
        end
      end
      default: begin
        state <= S_IDLE;
      end
    endcase
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end
  end

endmodule

### tb/okl_tb_pkg.sv
`timescale 1ns / 1ps
package okl_tb_pkg;
  import okl_pkg::*;

  localparam int LIST_DEPTH = 16;
  localparam int REPORT_MAX = 10;

  // modes the block does not define
  localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

  typedef struct {
    key_t              entry_key;
    logic              found;
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  entry_count;
    logic              last;
  } list_result_t;

  class key_list_scoreboard;
    key_t         slots[LIST_DEPTH];
    int           fill;
    list_result_t due_results[$];
    int unsigned  mismatches;

    function new();
      fill = 0;
      mismatches = 0;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function void queue_result(key_t k, logic f, logic [STAT_W-1:0] s, logic l);
      list_result_t r;
      r.entry_key   = k;
      r.found       = f;
      r.status      = s;
      r.entry_count = CNT_W'(fill);
      r.last        = l;
      due_results.push_back(r);
    endfunction

    function void drop_slot(int idx);
      for (int i = idx; i + 1 < fill; i++) slots[i] = slots[i + 1];
      fill--;
    endfunction

    function void note_request(logic [MODE_W-1:0] m, key_t k, logic [POS_W-1:0] p);
      int hit_at;
      hit_at = -1;
      for (int i = 0; i < fill; i++) begin
        if (hit_at < 0 && slots[i] == k) hit_at = i;
      end
      case (m)
        MODE_INS_HEAD, MODE_INS_TAIL: begin
          if (fill >= LIST_DEPTH) begin
            queue_result('0, 1'b0, STAT_FULL, 1'b1);
          end else begin
            if (m == MODE_INS_HEAD) begin
              for (int i = fill; i > 0; i--) slots[i] = slots[i - 1];
              slots[0] = k;
            end else begin
              slots[fill] = k;
            end
            fill++;
            queue_result('0, 1'b0, STAT_OK, 1'b1);
          end
        end
        MODE_REM_KEY: begin
          if (hit_at >= 0) begin
            drop_slot(hit_at);
            queue_result('0, 1'b1, STAT_OK, 1'b1);
          end else begin
            queue_result('0, 1'b0, STAT_NOTFOUND, 1'b1);
          end
        end
        MODE_REM_POS: begin
          if (int'(p) < fill) begin
            drop_slot(int'(p));
            queue_result('0, 1'b1, STAT_OK, 1'b1);
          end else begin
            queue_result('0, 1'b0, STAT_NOTFOUND, 1'b1);
          end
        end
        MODE_EXISTS: begin
          queue_result('0, hit_at >= 0, STAT_OK, 1'b1);
        end
        MODE_DUMP: begin
          if (fill == 0) begin
            queue_result('0, 1'b0, STAT_OK, 1'b1);
          end else begin
            for (int i = 0; i < fill; i++) queue_result(slots[i], 1'b1, STAT_OK, i == fill - 1);
          end
        end
        default: begin
          queue_result('0, 1'b0, STAT_OK, 1'b1);
        end
      endcase
    endfunction

    function void check_result(key_t k, logic f, logic [STAT_W-1:0] s,
                               logic [CNT_W-1:0] c, logic l);
      list_result_t want;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected result: key %0d found %0b status %0d count %0d last %0b",
                   k, f, s, c, l);
        return;
      end
      want = due_results.pop_front();
      if (k !== want.entry_key || f !== want.found || s !== want.status ||
          c !== want.entry_count || l !== want.last) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display("result mismatch: exp key %0d found %0b status %0d count %0d last %0b",
                   want.entry_key, want.found, want.status, want.entry_count, want.last);
          $display("                 got key %0d found %0b status %0d count %0d last %0b",
                   k, f, s, c, l);
        end
      end
    endfunction
  endclass

endpackage

### tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import okl_pkg::*;
  import okl_tb_pkg::*;

  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_LIMIT  = 5000;
  localparam int RANDOM_ITEMS = 95;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [MODE_W-1:0] mode = '0;
  key_t              key = '0;
  logic [POS_W-1:0]  position = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  key_t              entry_key;
  logic              found;
  logic [STAT_W-1:0] status;
  logic [CNT_W-1:0]  entry_count;
  logic              last;

  key_list_scoreboard list_sb;
  key_t               key_pool[8];
  bit                 hold_req = 1'b0;
  int                 quiet_cycles = 0;
  int                 burst_left = 0;

  ordered_key_list_engine_top #(.CAPACITY(LIST_DEPTH)) i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .mode        (mode),
    .key         (key),
    .position    (position),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .entry_key   (entry_key),
    .found       (found),
    .status      (status),
    .entry_count (entry_count),
    .last        (last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic key_t pick_key();
    if ($urandom_range(0, 3) != 0) return key_pool[$urandom_range(0, 7)];
    return key_t'($urandom);
  endfunction

  function automatic logic [POS_W-1:0] pick_position();
    if ($urandom_range(0, 4) == 0) return POS_W'($urandom_range(0, 63));
    return POS_W'($urandom_range(0, LIST_DEPTH + 1));
  endfunction

  function automatic logic [MODE_W-1:0] pick_mode(bit filling);
    int r;
    r = $urandom_range(0, 99);
    if (filling) begin
      if (r < 30) return MODE_INS_HEAD;
      if (r < 60) return MODE_INS_TAIL;
      if (r < 70) return MODE_REM_KEY;
      if (r < 78) return MODE_REM_POS;
      if (r < 87) return MODE_EXISTS;
    end else begin
      if (r < 15) return MODE_INS_HEAD;
      if (r < 30) return MODE_INS_TAIL;
      if (r < 55) return MODE_REM_KEY;
      if (r < 75) return MODE_REM_POS;
      if (r < 85) return MODE_EXISTS;
    end
    if (r < 96) return MODE_DUMP;
    return r[0] ? MODE_SPARE_HI : MODE_SPARE_LO;
  endfunction

  task automatic pace_input();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 15);
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_request(logic [MODE_W-1:0] m, key_t k, logic [POS_W-1:0] p);
    in_valid <= 1'b1;
    mode     <= m;
    key      <= k;
    position <= p;
    do @(posedge clk); while (in_stall);
    list_sb.note_request(m, k, p);
    pace_input();
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (list_sb.pending() != 0);
  endtask

  // receiver stall pattern, with one long hold on request
  initial begin
    int style;
    int rx_cycle;
    style = 0;
    rx_cycle = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        rx_cycle++;
        if (rx_cycle % 64 == 0) style = $urandom_range(0, 3);
        case (style)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 9) < 3);
          2: out_stall <= ($urandom_range(0, 9) < 7);
          default: out_stall <= (rx_cycle % 5 < 2);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      list_sb.check_result(entry_key, found, status, entry_count, last);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    list_sb = new();
    key_pool[0] = 32'sh7fffffff;
    key_pool[1] = 32'sh80000000;
    key_pool[2] = '0;
    key_pool[3] = -32'sd1;
    for (int i = 4; i < 8; i++) key_pool[i] = key_t'($urandom);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty list
    send_request(MODE_DUMP, '0, '0);
    send_request(MODE_REM_KEY, 32'sd5, '0);
    send_request(MODE_REM_POS, '0, '0);
    send_request(MODE_EXISTS, '0, '0);
    // extremes, duplicate key
    send_request(MODE_INS_HEAD, 32'sh7fffffff, '0);
    send_request(MODE_INS_TAIL, 32'sh80000000, 6'd63);
    send_request(MODE_INS_HEAD, -32'sd1, '0);
    send_request(MODE_INS_TAIL, '0, '0);
    send_request(MODE_INS_TAIL, -32'sd1, '0);
    send_request(MODE_DUMP, '0, '0);
    send_request(MODE_EXISTS, 32'sh80000000, '0);
    send_request(MODE_EXISTS, 32'sd12345, '0);
    send_request(MODE_REM_KEY, -32'sd1, '0);
    send_request(MODE_REM_POS, '0, 6'd63);
    send_request(MODE_REM_POS, '0, 6'd4);
    send_request(MODE_REM_POS, '0, 6'd3);
    send_request(MODE_SPARE_LO, 32'sh7fffffff, 6'd63);
    send_request(MODE_SPARE_HI, '0, '0);
    send_request(MODE_DUMP, '0, '0);

    // fill up, then push against a full list
    while (list_sb.fill < LIST_DEPTH)
      send_request($urandom_range(0, 1) ? MODE_INS_TAIL : MODE_INS_HEAD,
                   pick_key(), pick_position());
    send_request(MODE_INS_HEAD, pick_key(), pick_position());
    send_request(MODE_INS_TAIL, pick_key(), pick_position());
    send_request(MODE_DUMP, pick_key(), pick_position());

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 40) hold_req = 1'b1;
      if (n == 90) wait_drained();
      send_request(pick_mode((n / 25) % 2 == 1), pick_key(), pick_position());
    end

    wait_drained();
    repeat (40) @(posedge clk);
    if (list_sb.mismatches == 0 && list_sb.pending() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
